/* sv/blqt_pkg.sv */
// ----------------------------------------------------------------------------
// blqt_pkg
// Shared types and constants of the beacon link quality tracker.
// ----------------------------------------------------------------------------
package blqt_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAG,
        ST_RUN,
        ST_FIN
    } t_state;

    // Item kinds
    localparam logic [1:0] OP_BEACON = 2'd0;
    localparam logic [1:0] OP_EVAL   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_SELF_ID    = 2'd0;
    localparam logic [1:0] CFG_SOLID_SECS = 2'd1;
    localparam logic [1:0] CFG_FIT_HOLD   = 2'd2;

    localparam logic [31:0] TAG_MULT    = 32'd2654435761;
    localparam logic [7:0]  RECENT_MASK = 8'h07;

    // One slot's record, as it travels along the ring
    typedef struct packed {
        logic [7:0]  seen;
        logic [7:0]  mutual;
        logic [31:0] heard_time;
        logic [7:0]  tag;
    } t_rec;

    // Hashed tag of a node number; zero maps to one
    function automatic logic [7:0] tag_of(input logic [31:0] id);
        logic [31:0] p;
        p = id * TAG_MULT;
        return (p[31:24] != 8'd0) ? p[31:24] : 8'd1;
    endfunction

    // Count of set bits in a record
    function automatic logic [3:0] ones(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    // Position of the highest set bit plus one
    function automatic logic [3:0] span_of(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

/* sv/blqt_cell.sv */
// ----------------------------------------------------------------------------
// blqt_cell
// One slot record of the ring; takes its neighbor's record on each shift.
// ----------------------------------------------------------------------------
module blqt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  blqt_pkg::t_rec i_rec,
    output blqt_pkg::t_rec o_rec
);

    blqt_pkg::t_rec r_rec;

    // Hold, or take the neighbor's record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= '0;
        end else if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

/* sv/beacon_link_quality_tracker_top.sv */
// ----------------------------------------------------------------------------
// beacon_link_quality_tracker_top
// Per-slot beacon history tracker with fitness hysteresis and slot queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis (tuser = op, tdata = slot, sender, holds,
//   own tag, time). Each item gives exactly one result item on m_axis.
//   The slot records sit in a ring of SLOTS cells that rotates one place a
//   cycle while an item runs; one processing stage at the head ages, updates
//   or inspects the record passing by. Every item makes one full revolution.
//   An item passes the tag state, the ring revolution and the finish state,
//   where its result is loaded; one item at a time, so no new item is taken
//   before then, including any wait for the receiver.
//   The result sits in an output register; s_axis_tready rises again as soon
//   as it is loaded. If the receiver stalls with a result still held, the
//   next item finishes its revolution and waits until the held one is taken.
//   Synchronous active-low reset clears all records, the fitness flag and the
//   configuration registers to defaults; no clearing pass is needed. The user
//   writes configuration on i_cfg_we only with no item in flight; not enforced.
// ----------------------------------------------------------------------------
module beacon_link_quality_tracker_top #(
    parameter int SLOTS       = 32,
    parameter int PERIOD_MS   = 1000,
    parameter int RECORD_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] slot, [39:8] sender_id, [40] holds_slot, [48:41] reported_own_tag,
    // [80:49] now_ms, [87:81] zero
    input  logic [87:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] fit, [1] hearing_poorly, [2] slot_poor, [8:3] heard_slots,
    // [14:9] solid_slots, [15] zero
    output logic [15:0] m_axis_tdata
);

    localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GRACE = PERIOD_MS / 4;
    localparam logic [7:0] REC_MASK = 8'((1 << RECORD_BITS) - 1);
    localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

    // Record aligned to now, with a quarter-period grace before a miss
    function automatic logic [7:0] age(input logic [7:0] bits, input logic [31:0] since);
        logic [31:0] v;
        logic [3:0]  m;
        v = since - 32'(GRACE);
        m = 4'd0;
        for (int k = 1; k < RECORD_BITS; k++) begin
            if (v >= 32'(k * PERIOD_MS)) begin
                m = m + 4'd1;
            end
        end
        if (since <= 32'(PERIOD_MS + GRACE)) begin
            return bits & REC_MASK;
        end else if (v >= 32'(RECORD_BITS * PERIOD_MS)) begin
            return 8'd0;
        end
        return (bits << m) & REC_MASK;
    endfunction

    // Configuration registers
    logic [31:0] r_self_id;
    logic [3:0]  r_solid_secs;
    logic [15:0] r_fit_hold;
    logic [7:0]  r_self_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id    <= 32'd0;
            r_solid_secs <= 4'd3;
            r_fit_hold   <= 16'd5000;
            r_self_tag   <= 8'd1;
        end else begin
            r_self_tag <= blqt_pkg::tag_of(r_self_id);
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    blqt_pkg::CFG_SELF_ID:    r_self_id    <= i_cfg_data;
                    blqt_pkg::CFG_SOLID_SECS: r_solid_secs <= i_cfg_data[3:0];
                    blqt_pkg::CFG_FIT_HOLD:   r_fit_hold   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Item registers
    logic [1:0]  r_op;
    logic [7:0]  r_slot;
    logic [31:0] r_sender;
    logic        r_holds;
    logic [7:0]  r_own_tag;
    logic [31:0] r_now;
    logic [7:0]  r_stag;

    blqt_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          w_accept;

    assign s_axis_tready = (r_state == blqt_pkg::ST_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= s_axis_tuser;
            r_slot    <= s_axis_tdata[7:0];
            r_sender  <= s_axis_tdata[39:8];
            r_holds   <= s_axis_tdata[40];
            r_own_tag <= s_axis_tdata[48:41];
            r_now     <= s_axis_tdata[80:49];
        end
        if (r_state == blqt_pkg::ST_TAG) begin
            r_stag <= blqt_pkg::tag_of(r_sender);
        end
    end

    // Ring of slot records
    blqt_pkg::t_rec w_rec [SLOTS];
    blqt_pkg::t_rec w_tail;
    logic           w_shift;

    assign w_shift = (r_state == blqt_pkg::ST_RUN);

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        blqt_pkg::t_rec w_in;
        if (g == SLOTS - 1) begin : g_tail
            assign w_in = w_tail;
        end else begin : g_mid
            assign w_in = w_rec[g+1];
        end
        blqt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_rec   (w_in),
            .o_rec   (w_rec[g])
        );
    end

    // Head processing: age, update or inspect the passing record
    logic [31:0] w_since;
    logic [31:0] w_round;
    logic [3:0]  w_periods;
    logic [7:0]  w_seen_a, w_mut_a, w_seen_s, w_mut_s;
    logic        w_hit;
    logic [3:0]  w_ones, w_span;

    always_comb begin
        w_since = r_now - w_rec[0].heard_time;
        // Half-period rounding wraps modulo 2^32 like the elapsed time itself
        w_round = w_since + 32'(PERIOD_MS / 2);
        w_periods = 4'd0;
        for (int k = 1; k < RECORD_BITS; k++) begin
            if (w_round >= 32'(k * PERIOD_MS)) begin
                w_periods = w_periods + 4'd1;
            end
        end
        w_seen_a = age(w_rec[0].seen, w_since);
        w_mut_a  = age(w_rec[0].mutual, w_since);
        w_ones   = blqt_pkg::ones(w_seen_a);
        w_span   = blqt_pkg::span_of(w_seen_a);
        w_hit    = (r_slot == 8'(r_cnt));
        w_tail   = w_rec[0];
        if (r_op == blqt_pkg::OP_BEACON && w_hit) begin
            if (w_rec[0].tag != r_stag || w_round >= 32'(RECORD_BITS * PERIOD_MS)) begin
                w_seen_s = 8'd0;
                w_mut_s  = 8'd0;
            end else begin
                w_seen_s = (w_rec[0].seen << w_periods) & REC_MASK;
                w_mut_s  = (w_rec[0].mutual << w_periods) & REC_MASK;
            end
            w_tail.seen   = w_seen_s | 8'd1;
            w_tail.mutual = w_mut_s | {7'd0, r_holds && (r_own_tag == r_self_tag)};
            w_tail.heard_time = r_now;
            w_tail.tag = r_stag;
        end else begin
            w_seen_s = 8'd0;
            w_mut_s  = 8'd0;
        end
    end

    // Accumulators over the revolution
    logic [5:0] r_heard, r_solid;
    logic [8:0] r_got, r_due;
    logic       r_slot_poor;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_heard     <= 6'd0;
            r_solid     <= 6'd0;
            r_got       <= 9'd0;
            r_due       <= 9'd0;
            r_slot_poor <= 1'b0;
        end else if (w_shift) begin
            if (r_op == blqt_pkg::OP_EVAL) begin
                if (w_ones >= 4'd2) begin
                    r_heard <= r_heard + 6'd1;
                    if (blqt_pkg::ones(w_mut_a) >= r_solid_secs) begin
                        r_solid <= r_solid + 6'd1;
                    end
                end
                if (w_span >= 4'd2 && (w_seen_a & blqt_pkg::RECENT_MASK) != 8'd0) begin
                    r_got <= r_got + 9'(w_ones);
                    r_due <= r_due + 9'(w_span);
                end
            end
            if (r_op == blqt_pkg::OP_QUERY && w_hit && w_rec[0].tag == r_stag) begin
                r_slot_poor <= (w_span >= 4'd2) &&
                               ({2'd0, w_ones} << 2) < (6'(w_span) * 6'd3);
            end
        end
    end

    // Sequencer
    logic w_fin_go;
    assign w_fin_go = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blqt_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == blqt_pkg::ST_RUN) begin
                r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + CW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            blqt_pkg::ST_IDLE: if (w_accept) n_state = blqt_pkg::ST_TAG;
            blqt_pkg::ST_TAG:  n_state = blqt_pkg::ST_RUN;
            blqt_pkg::ST_RUN:  if (r_cnt == LAST) n_state = blqt_pkg::ST_FIN;
            blqt_pkg::ST_FIN:  if (w_fin_go) n_state = blqt_pkg::ST_IDLE;
            default:           n_state = blqt_pkg::ST_IDLE;
        endcase
    end

    // Fitness hysteresis and result register
    logic        r_fit;
    logic [31:0] r_settled;
    logic        r_out_valid;
    logic [15:0] r_out;
    logic        w_want, w_fit_n, w_poor_hear, w_eval;

    always_comb begin
        w_eval = (r_op == blqt_pkg::OP_EVAL);
        w_poor_hear = ({2'd0, r_got} << 2) < (11'(r_due) * 11'd3);
        w_want = (r_solid != 6'd0) &&
                 ((r_fit ? 8'(r_solid) * 8'd3 : 8'(r_solid) * 8'd2) >= 8'(r_heard));
        w_fit_n = r_fit;
        if (w_eval && w_want != r_fit && (r_now - r_settled) >= 32'(r_fit_hold)) begin
            w_fit_n = w_want;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit       <= 1'b0;
            r_settled   <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == blqt_pkg::ST_FIN && w_fin_go) begin
                r_out_valid <= 1'b1;
                if (w_eval && (w_want == r_fit || w_fit_n != r_fit)) begin
                    r_settled <= r_now;
                end
                r_fit <= w_fit_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == blqt_pkg::ST_FIN && w_fin_go) begin
            r_out <= {1'b0,
                      w_eval ? r_solid : 6'd0,
                      w_eval ? r_heard : 6'd0,
                      r_slot_poor,
                      w_eval && w_poor_hear,
                      w_fit_n};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Checks
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blqt_pkg::ST_RUN && r_cnt == LAST) |=> (r_state == blqt_pkg::ST_FIN))
        else $error("ring revolution did not end in finish");

    a_fit_only_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != blqt_pkg::ST_FIN) |=> $stable(r_fit))
        else $error("fitness changed outside finish");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blqt_pkg::ST_IDLE) |-> (r_cnt == '0))
        else $error("ring not aligned when idle");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the beacon link quality tracker: directed table,
// then random beacon/evaluate/query traffic checked against an inline model.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;
    localparam int PERIOD = 1000;
    localparam int RBITS = 8;
    localparam int LIMIT = 2_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // first member sits in the highest bits
    typedef struct packed {
        logic [5:0]  solid;
        logic [5:0]  heard;
        logic        slot_poor;
        logic        poor_hear;
        logic        fit;
    } t_res;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  slot;
        logic [31:0] sender;
        logic        holds;
        logic [7:0]  own_tag;
        logic [31:0] now;
        bit          typed;
        t_res        res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    beacon_link_quality_tracker_top i_dut (.*);

    // model state
    logic [7:0]  seen_q [SLOTS];
    logic [7:0]  mut_q [SLOTS];
    logic [31:0] heard_at [SLOTS];
    logic [7:0]  tag_q [SLOTS];
    logic        fit_q;
    logic [31:0] settled_at;
    logic [31:0] my_id;
    logic [3:0]  solid_need;
    logic [15:0] hold_ms;

    t_res pending_results[$];
    int   errors;
    int   snd_idle, rcv_idle;
    logic [31:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] hash_tag(input logic [31:0] id);
        logic [31:0] p;
        p = id * 32'd2654435761;
        return (p[31:24] != 0) ? p[31:24] : 8'd1;
    endfunction

    function automatic int popcnt(input logic [7:0] b);
        int n;
        n = 0;
        for (int i = 0; i < 8; i++) n += b[i];
        return n;
    endfunction

    function automatic int msb_span(input logic [7:0] b);
        int n;
        n = 0;
        for (int i = 0; i < 8; i++) if (b[i]) n = i + 1;
        return n;
    endfunction

    // align a record to now with a quarter-period grace
    function automatic logic [7:0] age_rec(input logic [7:0] b, input logic [31:0] since);
        logic [31:0] miss;
        if (since <= PERIOD + PERIOD / 4) return b;
        miss = (since - PERIOD / 4) / PERIOD;
        if (miss >= RBITS) return 8'd0;
        return b << miss;
    endfunction

    function automatic t_res predict_link(input t_row r);
        t_res o;
        logic [7:0]  tg, sn, mu;
        logic [31:0] per, since;
        int got, due, hd, sd;
        logic want;
        o = '0;
        if (r.op == blqt_pkg::OP_BEACON && r.slot < SLOTS) begin
            tg = hash_tag(r.sender);
            per = (r.now - heard_at[r.slot] + PERIOD / 2) / PERIOD;
            if (tag_q[r.slot] != tg || per >= RBITS) begin
                seen_q[r.slot] = 0;
                mut_q[r.slot] = 0;
            end else begin
                seen_q[r.slot] = seen_q[r.slot] << per;
                mut_q[r.slot] = mut_q[r.slot] << per;
            end
            seen_q[r.slot][0] = 1'b1;
            if (r.holds && r.own_tag == hash_tag(my_id)) mut_q[r.slot][0] = 1'b1;
            heard_at[r.slot] = r.now;
            tag_q[r.slot] = tg;
        end else if (r.op == blqt_pkg::OP_EVAL) begin
            got = 0; due = 0; hd = 0; sd = 0;
            for (int s = 0; s < SLOTS; s++) begin
                since = r.now - heard_at[s];
                sn = age_rec(seen_q[s], since);
                mu = age_rec(mut_q[s], since);
                if (popcnt(sn) >= 2) begin
                    hd++;
                    if (popcnt(mu) >= solid_need) sd++;
                end
                if (msb_span(sn) >= 2 && (sn & blqt_pkg::RECENT_MASK) != 0) begin
                    got += popcnt(sn);
                    due += msb_span(sn);
                end
            end
            o.poor_hear = got * 4 < due * 3;
            o.heard = 6'(hd);
            o.solid = 6'(sd);
            want = sd > 0 && sd * (fit_q ? 3 : 2) >= hd;
            if (want == fit_q) settled_at = r.now;
            else if (r.now - settled_at >= {16'd0, hold_ms}) begin
                fit_q = want;
                settled_at = r.now;
            end
        end else if (r.op == blqt_pkg::OP_QUERY) begin
            if (r.slot < SLOTS && tag_q[r.slot] == hash_tag(r.sender)) begin
                sn = age_rec(seen_q[r.slot], r.now - heard_at[r.slot]);
                o.slot_poor = msb_span(sn) >= 2 && popcnt(sn) * 4 < msb_span(sn) * 3;
            end
        end
        o.fit = fit_q;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // check results against the oldest expectation
    always @(posedge i_clk) begin
        t_res g, w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            g = t_res'(m_axis_tdata[14:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                w = pending_results.pop_front();
                if (g.fit != w.fit) report_mismatch("fit", g.fit, w.fit);
                if (g.poor_hear != w.poor_hear)
                    report_mismatch("hearing_poorly", g.poor_hear, w.poor_hear);
                if (g.slot_poor != w.slot_poor)
                    report_mismatch("slot_poor", g.slot_poor, w.slot_poor);
                if (g.heard != w.heard) report_mismatch("heard_slots", g.heard, w.heard);
                if (g.solid != w.solid) report_mismatch("solid_slots", g.solid, w.solid);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end

    // the caller drops the write enable after its last write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            blqt_pkg::CFG_SELF_ID:    my_id = val;
            blqt_pkg::CFG_SOLID_SECS: solid_need = val[3:0];
            blqt_pkg::CFG_FIT_HOLD:   hold_ms = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain_link;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // the caller drops tvalid after its last item
    task automatic send_item(input t_row r);
        t_res p;
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {7'd0, r.now, r.own_tag, r.holds, r.sender, r.slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = predict_link(r);
        if (r.typed && p != r.res) report_mismatch("directed row", int'(p), int'(r.res));
        pending_results.push_back(p);
    endtask

    function automatic t_row mk(input logic [1:0] op, input logic [7:0] slot,
                                input logic [31:0] snd, input logic holds,
                                input logic [7:0] tg, input logic [31:0] now);
        t_row r;
        r.op = op; r.slot = slot; r.sender = snd; r.holds = holds;
        r.own_tag = tg; r.now = now; r.typed = 0; r.res = '0;
        return r;
    endfunction

    function automatic t_row mk_typed(input t_row r, input t_res res);
        r.typed = 1; r.res = res;
        return r;
    endfunction

    // random item: mostly beacons from a few stable senders
    function automatic t_row rand_item(input int phase);
        t_row r;
        int k;
        logic [31:0] snd;
        k = $urandom_range(99);
        if ($urandom_range(9) == 0) snd = $urandom();
        else snd = $urandom_range(7) << ($urandom_range(1) ? 28 : 0);
        clock_ms += (k < 5) ? $urandom() : $urandom_range(400);
        r = mk(blqt_pkg::OP_BEACON,
               8'($urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(7)),
               snd, $urandom_range(3) != 0,
               $urandom_range(3) != 0 ? hash_tag(my_id) : 8'($urandom_range(255)),
               clock_ms);
        if (k >= 70 && k < 85) r.op = blqt_pkg::OP_EVAL;
        else if (k >= 85 && k < 97) r.op = blqt_pkg::OP_QUERY;
        else if (k >= 97) r.op = OP_UNUSED;
        if (phase == 1) r.slot[7:3] = 0;
        return r;
    endfunction

    initial begin
        t_row rows[$];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        errors = 0; snd_idle = 23; rcv_idle = 58; clock_ms = 0;
        my_id = 0; solid_need = 3; hold_ms = 5000; fit_q = 0; settled_at = 0;
        for (int s = 0; s < SLOTS; s++) begin
            seen_q[s] = 0; mut_q[s] = 0; heard_at[s] = 0; tag_q[s] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: after reset, extremes, unused op, slot none, tag mismatch
        rows.push_back(mk_typed(mk(blqt_pkg::OP_EVAL, 0, 0, 0, 0, 0), '0));
        rows.push_back(mk_typed(mk(blqt_pkg::OP_QUERY, 255, 32'hFFFF_FFFF, 1, 255, '1), '0));
        rows.push_back(mk_typed(mk(OP_UNUSED, 31, 32'hFFFF_FFFF, 1, 8'hFF, '1), '0));
        rows.push_back(mk_typed(mk(blqt_pkg::OP_BEACON, 32, 5, 1, 0, 100), '0));
        for (int i = 0; i < 5; i++)
            rows.push_back(mk(blqt_pkg::OP_BEACON, 31, 32'hFFFF_FFFF, 1, hash_tag(0),
                              i * 1000));
        rows.push_back(mk(blqt_pkg::OP_BEACON, 31, 32'hFFFF_FFFF, 0, 0, 7000));
        rows.push_back(mk(blqt_pkg::OP_BEACON, 0, 0, 1, hash_tag(0), 32'hFFFF_FF00));
        rows.push_back(mk(blqt_pkg::OP_BEACON, 0, 0, 1, hash_tag(0), 32'h0000_02E8));
        rows.push_back(mk_typed(mk(blqt_pkg::OP_QUERY, 31, 1, 0, 0, 7000), '0));
        rows.push_back(mk(blqt_pkg::OP_QUERY, 31, 32'hFFFF_FFFF, 0, 0, 9000));
        rows.push_back(mk(blqt_pkg::OP_EVAL, 0, 0, 0, 0, 7300));
        rows.push_back(mk(blqt_pkg::OP_EVAL, 0, 0, 0, 0, 13000));
        rows.push_back(mk(blqt_pkg::OP_BEACON, 31, 7, 1, 0, 14000));
        rows.push_back(mk(blqt_pkg::OP_EVAL, 0, 0, 0, 0, '1));
        foreach (rows[i]) send_item(rows[i]);
        s_axis_tvalid <= 1'b0;
        drain_link();

        // random traffic across register settings, idling pattern per phase
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(blqt_pkg::CFG_SELF_ID, 0);
                          write_reg(blqt_pkg::CFG_SOLID_SECS, 0);
                          write_reg(blqt_pkg::CFG_FIT_HOLD, 0); end
                1: begin write_reg(blqt_pkg::CFG_SELF_ID, 32'hFFFF_FFFF);
                          write_reg(blqt_pkg::CFG_SOLID_SECS, 15);
                          write_reg(blqt_pkg::CFG_FIT_HOLD, 16'hFFFF); end
                2: begin write_reg(blqt_pkg::CFG_SELF_ID, $urandom());
                          write_reg(blqt_pkg::CFG_SOLID_SECS, 1);
                          write_reg(blqt_pkg::CFG_FIT_HOLD, 500); end
                3: begin write_reg(blqt_pkg::CFG_SOLID_SECS, 8);
                          write_reg(blqt_pkg::CFG_FIT_HOLD, 2000); end
                4: begin write_reg(blqt_pkg::CFG_SELF_ID, 32'h1234_5678);
                          write_reg(blqt_pkg::CFG_SOLID_SECS, 2);
                          write_reg(blqt_pkg::CFG_FIT_HOLD, 1); end
                default: begin write_reg(blqt_pkg::CFG_SOLID_SECS, 3);
                          write_reg(blqt_pkg::CFG_FIT_HOLD, 300); end
            endcase
            i_cfg_we <= 1'b0;
            if (ph == 2) begin snd_idle = 58; rcv_idle = 23; end
            if (ph == 4) begin snd_idle = 0; rcv_idle = 0; end
            for (int n = 0; n < 115; n++) send_item(rand_item(ph % 2));
            s_axis_tvalid <= 1'b0;
            drain_link();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/blqt_pkg.sv
sv/blqt_cell.sv
sv/beacon_link_quality_tracker_top.sv
verif/tb.sv
